[rtl/dsa_pkg.sv]
`default_nettype none
package dsa_pkg;

	localparam int CAPACITY = 1024;
	localparam int SLOT_W   = 10;
	localparam int CNT_W    = 11;
	localparam int WORD_W   = 32;
	localparam int BIT_W    = 5;
	localparam int ROW_W    = SLOT_W - BIT_W;
	localparam int ROWS     = CAPACITY / WORD_W;
	localparam int STAT_W   = 3;

	localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAPACITY);

	typedef enum logic [1:0] {
		MODE_ALLOC_ONE   = 2'd0,
		MODE_ALLOC_RANGE = 2'd1,
		MODE_FREE_ONE    = 2'd2,
		MODE_FREE_RANGE  = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_EXHAUSTED = 3'd1,
		ST_RANGE     = 3'd2,
		ST_FREE      = 3'd3,
		ST_EMPTY     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP,
		S_PCHK,
		S_PBIT,
		S_BRD,
		S_BSET,
		S_RTEST,
		S_RRD,
		S_REV,
		S_RBUMP,
		S_VRD,
		S_VEV,
		S_WRD,
		S_WWR,
		S_FRD,
		S_FEV
	} state_t;

	typedef struct packed {
		logic              we;
		logic [ROW_W-1:0]  addr;
		logic [WORD_W-1:0] wdata;
	} map_req_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_W-1:0] waddr;
		logic [SLOT_W-1:0] wdata;
		logic [SLOT_W-1:0] raddr;
	} stk_req_t;

endpackage
`default_nettype wire

[rtl/dsa_bitmap.sv]
`default_nettype none
module dsa_bitmap (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire dsa_pkg::map_req_t      req,
	output logic [dsa_pkg::WORD_W-1:0]  rdata
);
	import dsa_pkg::*;

	logic [WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   valid_q;
	logic [WORD_W-1:0] rd_q;
	logic              vrd_q;

	// word storage: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rd_q <= mem[req.addr];
	end

	// row valid bits: an unwritten row reads as all free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vrd_q   <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.addr] <= 1'b1;
			end
			vrd_q <= valid_q[req.addr];
		end
	end

	assign rdata = vrd_q ? rd_q : '0;

endmodule
`default_nettype wire

[rtl/dsa_stack.sv]
`default_nettype none
module dsa_stack (
	input  wire logic                   clk,
	input  wire dsa_pkg::stk_req_t      req,
	output logic [dsa_pkg::SLOT_W-1:0]  rdata
);
	import dsa_pkg::*;

	logic [SLOT_W-1:0] mem [CAPACITY];
	logic [SLOT_W-1:0] rd_q;

	// push write and registered pop read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

	assign rdata = rd_q;

endmodule
`default_nettype wire

[rtl/dsa_ctrl.sv]
`default_nettype none
module dsa_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [1:0]             mode,
	input  wire logic [dsa_pkg::SLOT_W-1:0] slot,
	input  wire logic [dsa_pkg::CNT_W-1:0]  count,
	output logic                        done,
	output logic [dsa_pkg::SLOT_W-1:0]  first_slot,
	output logic [dsa_pkg::STAT_W-1:0]  status,
	input  wire logic                   cfg_we,
	input  wire logic [dsa_pkg::CNT_W-1:0]  cfg_wdata,
	output dsa_pkg::map_req_t           map_req,
	input  wire logic [dsa_pkg::WORD_W-1:0] map_rd,
	output dsa_pkg::stk_req_t           stk_req,
	input  wire logic [dsa_pkg::SLOT_W-1:0] stk_rd
);
	import dsa_pkg::*;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cap_q, cap_eff;
	logic [CNT_W-1:0]  depth_q, bump_q, hint_q, d_q, first_q, i_q, cnt_q;
	logic [SLOT_W-1:0] cur_q;
	logic              setv_q;
	logic              done_q;
	logic [SLOT_W-1:0] res_slot_q;
	status_t           res_stat_q;

	logic              fin;
	logic [SLOT_W-1:0] fin_slot;
	status_t           fin_stat;
	mode_t             md;
	logic              bit_set, last_i;
	logic [CNT_W:0]    range_end, scan_end, bump_end;
	logic [WORD_W-1:0] mask;

	assign md        = mode_t'(mode);
	assign cap_eff   = (cap_q > CAP_MAX) ? CAP_MAX : cap_q;
	assign bit_set   = map_rd[cur_q[BIT_W-1:0]];
	assign last_i    = (i_q + CNT_W'(1)) == cnt_q;
	assign range_end = {1'b0, CNT_W'(slot)} + {1'b0, count} - (CNT_W+1)'(1);
	assign scan_end  = {1'b0, first_q} + {1'b0, cnt_q};
	assign bump_end  = {1'b0, bump_q} + {1'b0, cnt_q};
	assign mask      = WORD_W'(1) << cur_q[BIT_W-1:0];

	// next state and result of the finishing cycle
	always_comb begin
		state_d  = state_q;
		fin      = 1'b0;
		fin_slot = '0;
		fin_stat = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					priority if (md == MODE_ALLOC_ONE ||
						(md == MODE_ALLOC_RANGE && count == CNT_W'(1))) begin
						state_d = S_POP;
					end else if (count == '0 &&
						(md == MODE_ALLOC_RANGE || md == MODE_FREE_RANGE)) begin
						fin      = 1'b1;
						fin_stat = ST_EMPTY;
					end else if (md == MODE_ALLOC_RANGE) begin
						state_d = S_RTEST;
					end else if (CNT_W'(slot) >= cap_eff) begin
						fin      = 1'b1;
						fin_stat = ST_RANGE;
					end else if (md == MODE_FREE_ONE || count == CNT_W'(1)) begin
						state_d = S_FRD;
					end else if (range_end >= {1'b0, cap_eff}) begin
						fin      = 1'b1;
						fin_stat = ST_RANGE;
					end else begin
						state_d = S_VRD;
					end
				end
			end
			S_POP: begin
				if (d_q == '0) begin
					if (bump_q >= cap_eff) begin
						fin      = 1'b1;
						fin_stat = ST_EXHAUSTED;
						state_d  = S_IDLE;
					end else begin
						state_d = S_BRD;
					end
				end else begin
					state_d = S_PCHK;
				end
			end
			S_PCHK: state_d = S_PBIT;
			S_PBIT: begin
				if (!bit_set) begin
					fin      = 1'b1;
					fin_slot = cur_q;
					state_d  = S_IDLE;
				end else begin
					state_d = S_POP;
				end
			end
			S_BRD: state_d = S_BSET;
			S_BSET: begin
				fin      = 1'b1;
				fin_slot = cur_q;
				state_d  = S_IDLE;
			end
			S_RTEST: state_d = (scan_end <= {1'b0, bump_q}) ? S_RRD : S_RBUMP;
			S_RRD:   state_d = S_REV;
			S_REV: begin
				priority if (bit_set) state_d = S_RTEST;
				else if (last_i)      state_d = S_WRD;
				else                  state_d = S_RRD;
			end
			S_RBUMP: begin
				if (bump_end > {1'b0, cap_eff}) begin
					fin      = 1'b1;
					fin_stat = ST_EXHAUSTED;
					state_d  = S_IDLE;
				end else begin
					state_d = S_WRD;
				end
			end
			S_VRD: state_d = S_VEV;
			S_VEV: begin
				priority if (!bit_set) begin
					fin      = 1'b1;
					fin_stat = ST_FREE;
					state_d  = S_IDLE;
				end else if (last_i) begin
					state_d = S_WRD;
				end else begin
					state_d = S_VRD;
				end
			end
			S_WRD: state_d = S_WWR;
			S_WWR: begin
				if (last_i) begin
					fin      = 1'b1;
					fin_slot = setv_q ? first_q[SLOT_W-1:0] : '0;
					state_d  = S_IDLE;
				end else begin
					state_d = S_WRD;
				end
			end
			S_FRD: state_d = S_FEV;
			S_FEV: begin
				fin     = 1'b1;
				state_d = S_IDLE;
				if (!bit_set) begin
					fin_stat = ST_FREE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		map_req.we    = 1'b0;
		map_req.addr  = cur_q[SLOT_W-1:BIT_W];
		map_req.wdata = map_rd | mask;
		stk_req.we    = 1'b0;
		stk_req.waddr = depth_q[SLOT_W-1:0];
		stk_req.wdata = cur_q;
		stk_req.raddr = SLOT_W'(d_q - CNT_W'(1));
		unique case (state_q)
			S_PCHK: map_req.addr = stk_rd[SLOT_W-1:BIT_W];
			S_PBIT: map_req.we = !bit_set;
			S_BSET: map_req.we = 1'b1;
			S_WWR: begin
				map_req.we    = 1'b1;
				map_req.wdata = setv_q ? (map_rd | mask) : (map_rd & ~mask);
			end
			S_FEV: begin
				map_req.we    = bit_set;
				map_req.wdata = map_rd & ~mask;
				stk_req.we    = bit_set && (depth_q != CAP_MAX);
			end
			default: begin
			end
		endcase
	end

	// sequencer state and results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			cap_q   <= CAP_MAX;
			depth_q <= '0;
			bump_q  <= '0;
			hint_q  <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			unique case (state_q)
				S_PBIT: if (!bit_set) depth_q <= d_q;
				S_BSET: begin
					depth_q <= d_q;
					bump_q  <= bump_q + CNT_W'(1);
				end
				S_REV: begin
					if (!bit_set && last_i && first_q == hint_q) begin
						hint_q <= CNT_W'(scan_end);
					end
				end
				S_RBUMP: begin
					if (bump_end <= {1'b0, cap_eff}) begin
						bump_q <= CNT_W'(bump_end);
					end
				end
				S_WWR: begin
					if (last_i && !setv_q && first_q < hint_q) begin
						hint_q <= first_q;
					end
				end
				S_FEV: begin
					if (bit_set) begin
						if (depth_q != CAP_MAX) begin
							depth_q <= depth_q + CNT_W'(1);
						end
						if (CNT_W'(cur_q) < hint_q) begin
							hint_q <= CNT_W'(cur_q);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// working registers of the current transaction
	always_ff @(posedge clk) begin
		if (fin) begin
			res_slot_q <= fin_slot;
			res_stat_q <= fin_stat;
		end
		unique case (state_q)
			S_IDLE: begin
				d_q     <= depth_q;
				first_q <= (md == MODE_ALLOC_RANGE) ? hint_q : CNT_W'(slot);
				cur_q   <= slot;
				cnt_q   <= count;
				i_q     <= '0;
			end
			S_POP: begin
				if (d_q == '0) begin
					cur_q <= bump_q[SLOT_W-1:0];
				end else begin
					d_q <= d_q - CNT_W'(1);
				end
			end
			S_PCHK: cur_q <= stk_rd;
			S_RTEST: begin
				cur_q <= first_q[SLOT_W-1:0];
				i_q   <= '0;
			end
			S_REV: begin
				priority if (bit_set) begin
					first_q <= CNT_W'(cur_q) + CNT_W'(1);
				end else if (last_i) begin
					cur_q  <= first_q[SLOT_W-1:0];
					i_q    <= '0;
					setv_q <= 1'b1;
				end else begin
					cur_q <= cur_q + SLOT_W'(1);
					i_q   <= i_q + CNT_W'(1);
				end
			end
			S_RBUMP: begin
				first_q <= bump_q;
				cur_q   <= bump_q[SLOT_W-1:0];
				i_q     <= '0;
				setv_q  <= 1'b1;
			end
			S_VEV: begin
				if (last_i) begin
					cur_q  <= first_q[SLOT_W-1:0];
					i_q    <= '0;
					setv_q <= 1'b0;
				end else begin
					cur_q <= cur_q + SLOT_W'(1);
					i_q   <= i_q + CNT_W'(1);
				end
			end
			S_WWR: begin
				cur_q <= cur_q + SLOT_W'(1);
				i_q   <= i_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign busy       = state_q != S_IDLE;
	assign done       = done_q;
	assign first_slot = res_slot_q;
	assign status     = res_stat_q;

endmodule
`default_nettype wire

[rtl/descriptor_slot_allocator_core.sv]
`default_nettype none
// channel   | ports                          | handshake
// ----------+--------------------------------+-------------------------------
// request   | mode, slot, count              | start high while busy low
// result    | first_slot, status             | done strobe, one cycle
// config    | cfg_wdata (capacity in use)    | cfg_we, any cycle while idle
//
// Errors found at decode finish from idle; a single free runs FRD, FEV. A
// single allocation runs POP, PCHK, PBIT per popped stack entry, then POP,
// BRD, BSET on the bump path (POP alone if exhausted). A range reads and
// then evaluates or writes each bitmap bit, plus RTEST per scan start and
// RBUMP for the bump check. The result strobes in the cycle after the last
// step, never held off. Reset clears the bitmap at once via row valid bits.
module descriptor_slot_allocator_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  mode,
	input  wire logic [dsa_pkg::SLOT_W-1:0]  slot,
	input  wire logic [dsa_pkg::CNT_W-1:0]   count,
	output logic                             done,
	output logic [dsa_pkg::SLOT_W-1:0]       first_slot,
	output logic [dsa_pkg::STAT_W-1:0]       status,
	input  wire logic                        cfg_we,
	input  wire logic [dsa_pkg::CNT_W-1:0]   cfg_wdata
);
	import dsa_pkg::*;

	map_req_t          map_req;
	stk_req_t          stk_req;
	logic [WORD_W-1:0] map_rd;
	logic [SLOT_W-1:0] stk_rd;

	dsa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.slot       (slot),
		.count      (count),
		.done       (done),
		.first_slot (first_slot),
		.status     (status),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.map_req    (map_req),
		.map_rd     (map_rd),
		.stk_req    (stk_req),
		.stk_rd     (stk_rd)
	);

	dsa_bitmap u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (map_req),
		.rdata  (map_rd)
	);

	dsa_stack u_stack (
		.clk   (clk),
		.req   (stk_req),
		.rdata (stk_rd)
	);

endmodule
`default_nettype wire
